@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL; they compile to nothing for
// synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that a condition never holds while out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hdl/epirc_pkg.sv @@
// ---------------------------------------------------------------------------
// epirc_pkg
// Types, register indexes, mode codes and reset values shared by the engine
// power, idle and rev controller.
// ---------------------------------------------------------------------------
package epirc_pkg;

    localparam int RPM_W      = 14;
    localparam int FRAC_W     = 12;
    localparam int OIL_W      = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    // Power mode codes
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACC     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRING  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLD_IDLE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARM_IDLE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_GAP  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_GAP  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_CORR = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_CORR = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALL      = 4'd7;

    // Register reset values
    localparam logic [RPM_W-1:0]  COLD_IDLE_RST  = 14'd1200;
    localparam logic [RPM_W-1:0]  WARM_IDLE_RST  = 14'd800;
    localparam logic [RPM_W-1:0]  SMALL_GAP_RST  = 14'd10;
    localparam logic [RPM_W-1:0]  LARGE_GAP_RST  = 14'd100;
    localparam logic [FRAC_W-1:0] SMALL_CORR_RST = 12'd410;
    localparam logic [FRAC_W-1:0] LARGE_CORR_RST = 12'd819;
    localparam logic [RPM_W-1:0]  REV_LIMIT_RST  = 14'd5500;
    localparam logic [RPM_W-1:0]  STALL_RST      = 14'd550;

    // Oil temperature at which the warm idle target applies
    localparam logic signed [OIL_W-1:0] OIL_WARM_C = 9'sd90;

    typedef struct packed {
        logic [RPM_W-1:0]  cold_idle_rpm;
        logic [RPM_W-1:0]  warm_idle_rpm;
        logic [RPM_W-1:0]  small_gap_rpm;
        logic [RPM_W-1:0]  large_gap_rpm;
        logic [FRAC_W-1:0] small_correction;
        logic [FRAC_W-1:0] large_correction;
        logic [RPM_W-1:0]  rev_limit_rpm;
        logic [RPM_W-1:0]  stall_rpm;
    } cfg_t;

    // Input transaction, last member in the lowest bits
    typedef struct packed {
        logic                    pad;
        logic signed [OIL_W-1:0] oil_temp;
        logic [RPM_W-1:0]        flywheel_speed;
        logic [RPM_W-1:0]        crank_speed;
        logic [FRAC_W-1:0]       brake_pedal;
        logic [FRAC_W-1:0]       accel_pedal;
        logic [FRAC_W-1:0]       clutch_pedal;
        logic [FRAC_W-1:0]       hand_brake;
        logic                    lights_request;
        logic                    key_turned;
    } in_item_t;

    // Result transaction, last member in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [MODE_W-1:0] mode_out;
        logic              starter_on;
        logic [FRAC_W-1:0] brake_out;
        logic [FRAC_W-1:0] throttle_out;
        logic [FRAC_W-1:0] clutch_out;
        logic [FRAC_W-1:0] hand_brake_out;
        logic              lights_out;
    } out_item_t;

endpackage

@@ hdl/epirc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// epirc_cfg_regs
// Configuration register file; out-of-range indexes are ignored and wide
// data is truncated to each register's width.
// ---------------------------------------------------------------------------
module epirc_cfg_regs
    import epirc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write transaction
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_COLD_IDLE:  cfg_next.cold_idle_rpm    = wr_data[RPM_W-1:0];
                REG_WARM_IDLE:  cfg_next.warm_idle_rpm    = wr_data[RPM_W-1:0];
                REG_SMALL_GAP:  cfg_next.small_gap_rpm    = wr_data[RPM_W-1:0];
                REG_LARGE_GAP:  cfg_next.large_gap_rpm    = wr_data[RPM_W-1:0];
                REG_SMALL_CORR: cfg_next.small_correction = wr_data[FRAC_W-1:0];
                REG_LARGE_CORR: cfg_next.large_correction = wr_data[FRAC_W-1:0];
                REG_REV_LIMIT:  cfg_next.rev_limit_rpm    = wr_data[RPM_W-1:0];
                REG_STALL:      cfg_next.stall_rpm        = wr_data[RPM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cold_idle_rpm    <= COLD_IDLE_RST;
            cfg_reg.warm_idle_rpm    <= WARM_IDLE_RST;
            cfg_reg.small_gap_rpm    <= SMALL_GAP_RST;
            cfg_reg.large_gap_rpm    <= LARGE_GAP_RST;
            cfg_reg.small_correction <= SMALL_CORR_RST;
            cfg_reg.large_correction <= LARGE_CORR_RST;
            cfg_reg.rev_limit_rpm    <= REV_LIMIT_RST;
            cfg_reg.stall_rpm        <= STALL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/epirc_core.sv @@
// ---------------------------------------------------------------------------
// epirc_core
// Mode transition and output logic for one control tick: starter and
// lights, idle correction and rev cut.
// ---------------------------------------------------------------------------
module epirc_core
    import epirc_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  in_item_t          item,
    input  cfg_t              cfg,
    output logic [MODE_W-1:0] mode_next,
    output out_item_t         result
);

    logic              turning;
    logic              cold;
    logic              engine_on;
    logic [RPM_W-1:0]  target;
    logic [RPM_W-1:0]  gap;
    logic [FRAC_W-1:0] throttle;

    assign turning = (item.crank_speed >= cfg.stall_rpm);

    // Advance the power mode
    always_comb begin
        mode_next = mode;
        unique case (mode)
            MODE_OFF, MODE_ACC: begin
                if (item.key_turned && !turning) mode_next = MODE_FIRING;
            end
            MODE_FIRING: begin
                if (turning) mode_next = MODE_RUNNING;
            end
            MODE_RUNNING: begin
                if (!turning) mode_next = MODE_ACC;
            end
            default: mode_next = mode;
        endcase
    end

    assign engine_on = (mode_next == MODE_FIRING) || (mode_next == MODE_RUNNING);

    // Pick idle target and work out the shortfall
    assign cold   = (item.oil_temp < OIL_WARM_C);
    assign target = cold ? cfg.cold_idle_rpm : cfg.warm_idle_rpm;
    assign gap    = (item.flywheel_speed < target) ? (target - item.flywheel_speed)
                                                   : '0;

    // While the engine is on, raise throttle to the idle correction, then cut at the rev limit
    always_comb begin
        throttle = item.accel_pedal;
        if (engine_on) begin
            if (gap > cfg.large_gap_rpm) begin
                if (cfg.large_correction > throttle) throttle = cfg.large_correction;
            end else if (gap > cfg.small_gap_rpm) begin
                if (cfg.small_correction > throttle) throttle = cfg.small_correction;
            end
            if (item.flywheel_speed >= cfg.rev_limit_rpm) throttle = '0;
        end
    end

    // Assemble the result
    always_comb begin
        result                = '0;
        result.lights_out     = item.lights_request && (mode_next != MODE_FIRING);
        result.hand_brake_out = item.hand_brake;
        result.clutch_out     = item.clutch_pedal;
        result.throttle_out   = throttle;
        result.brake_out      = item.brake_pedal;
        result.starter_on     = (mode_next == MODE_FIRING);
        result.mode_out       = mode_next;
    end

endmodule

@@ hdl/engine_power_idle_rev_controller_unit.sv @@
// ---------------------------------------------------------------------------
// engine_power_idle_rev_controller_unit: engine power mode, idle and rev cut
// Pipeline: input reg, then output reg; the power mode updates with the output reg.
// Throughput: one transaction per cycle unless the result side stalls.
// Reset: aresetn low clears both stages and sets the mode to off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module engine_power_idle_rev_controller_unit
    import epirc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: key_turned, lights_request, hand_brake, clutch_pedal, accel_pedal,
    //        brake_pedal, crank_speed, flywheel_speed, oil_temp, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: lights_out, hand_brake_out, clutch_out, throttle_out, brake_out,
    //        starter_on, mode_out, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    out_item_t         result;
    logic              advance;

    assign cfg_ready = 1'b1;

    epirc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    epirc_core u_core (
        .mode      (mode_reg),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .mode_next (mode_next),
        .result    (result)
    );

    // Move the held transaction on when the output register is free
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= MODE_OFF;
        end else begin
            if (s_tready) s1_valid_reg <= s_tvalid;
            if (advance) begin
                m_valid_reg <= 1'b1;
                mode_reg    <= mode_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) s1_item_reg <= in_item_t'(s_tdata);
        if (advance) m_item_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_item_reg;

    // Starter runs exactly in the firing mode
    `ASSERT_CLK(a_starter_mode, aclk, aresetn,
        m_valid_reg |-> (m_item_reg.starter_on == (m_item_reg.mode_out == MODE_FIRING)),
        "starter_on disagrees with the reported mode")
    // Lights are never on while the starter fires
    `ASSERT_NEVER(a_lights_off_firing, aclk, aresetn,
        m_valid_reg && m_item_reg.starter_on && m_item_reg.lights_out,
        "lights on while starter fires")
    // Mode only changes when a transaction moves to the output register
    `ASSERT_CLK(a_mode_hold, aclk, aresetn, !advance |=> $stable(mode_reg),
        "power mode changed without a transaction")
    // Reported mode matches the state register after each transaction
    `ASSERT_CLK(a_mode_report, aclk, aresetn, advance |=> (m_item_reg.mode_out == mode_reg),
        "reported mode differs from the mode register")

endmodule

@@ tb/sv/tb_engine_power_idle_rev_controller_unit.sv @@
// ---------------------------------------------------------------------------
// tb_engine_power_idle_rev_controller_unit
// Self-checking bench for the engine power, idle and rev controller. A
// clocked driver feeds control ticks from a queue. A clocked monitor predicts
// each result from its own mirror of the power mode and registers, and checks
// every returned result field by field. Register sets change between phases
// while the block is idle. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_engine_power_idle_rev_controller_unit;
    import epirc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    // Indexes outside the register file; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: register mirror and power mode
    cfg_t              ecu_regs;
    logic [MODE_W-1:0] model_mode;

    in_item_t  pending_ticks[$];
    out_item_t predicted_results[$];

    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   errs      = 0;
    int   hold_left = 0;
    logic hold_kick = 1'b0;
    logic s_took    = 1'b0;
    logic cfg_took  = 1'b0;

    engine_power_idle_rev_controller_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Count a failure; print only the first ten
    task automatic flag_error(string msg);
        errs++;
        if (errs <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    // Append a tick to the driver queue
    function automatic void queue_tick(in_item_t t);
        pending_ticks.insert(pending_ticks.size(), t);
    endfunction

    // Mirror a register write; wide values keep their low bits
    function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_COLD_IDLE:  ecu_regs.cold_idle_rpm    = val[RPM_W-1:0];
            REG_WARM_IDLE:  ecu_regs.warm_idle_rpm    = val[RPM_W-1:0];
            REG_SMALL_GAP:  ecu_regs.small_gap_rpm    = val[RPM_W-1:0];
            REG_LARGE_GAP:  ecu_regs.large_gap_rpm    = val[RPM_W-1:0];
            REG_SMALL_CORR: ecu_regs.small_correction = val[FRAC_W-1:0];
            REG_LARGE_CORR: ecu_regs.large_correction = val[FRAC_W-1:0];
            REG_REV_LIMIT:  ecu_regs.rev_limit_rpm    = val[RPM_W-1:0];
            REG_STALL:      ecu_regs.stall_rpm        = val[RPM_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the power mode by one tick and work out the commands
    function automatic out_item_t predict_tick(in_item_t t);
        out_item_t r;
        logic      turning;
        int        oil_c;
        int        target;
        int        fly;
        int        shortfall;
        int        thr;
        r       = '0;
        turning = t.crank_speed >= ecu_regs.stall_rpm;
        case (model_mode)
            MODE_OFF, MODE_ACC: begin
                if (t.key_turned && !turning) model_mode = MODE_FIRING;
            end
            MODE_FIRING: begin
                if (turning) model_mode = MODE_RUNNING;
            end
            default: begin
                if (!turning) model_mode = MODE_ACC;
            end
        endcase
        thr = int'(t.accel_pedal);
        if (model_mode == MODE_FIRING || model_mode == MODE_RUNNING) begin
            oil_c  = t.oil_temp;
            target = (oil_c < int'(OIL_WARM_C)) ? int'(ecu_regs.cold_idle_rpm)
                                                : int'(ecu_regs.warm_idle_rpm);
            fly       = int'(t.flywheel_speed);
            shortfall = (fly < target) ? target - fly : 0;
            // Large shortfall test wins over the small one
            if (shortfall > int'(ecu_regs.large_gap_rpm)) begin
                if (int'(ecu_regs.large_correction) > thr) thr = ecu_regs.large_correction;
            end else if (shortfall > int'(ecu_regs.small_gap_rpm)) begin
                if (int'(ecu_regs.small_correction) > thr) thr = ecu_regs.small_correction;
            end
            // Rev cut comes after the idle correction
            if (fly >= int'(ecu_regs.rev_limit_rpm)) thr = 0;
        end
        r.lights_out     = (model_mode == MODE_FIRING) ? 1'b0 : t.lights_request;
        r.hand_brake_out = t.hand_brake;
        r.clutch_out     = t.clutch_pedal;
        r.throttle_out   = FRAC_W'(thr);
        r.brake_out      = t.brake_pedal;
        r.starter_on     = (model_mode == MODE_FIRING);
        r.mode_out       = model_mode;
        return r;
    endfunction

    function automatic in_item_t tick_item(bit key, bit lights, int hand, int clutch,
                                           int accel, int brake, int crank, int fly,
                                           int oil);
        in_item_t t;
        t                = '0;
        t.key_turned     = key;
        t.lights_request = lights;
        t.hand_brake     = FRAC_W'(hand);
        t.clutch_pedal   = FRAC_W'(clutch);
        t.accel_pedal    = FRAC_W'(accel);
        t.brake_pedal    = FRAC_W'(brake);
        t.crank_speed    = RPM_W'(crank);
        t.flywheel_speed = RPM_W'(fly);
        t.oil_temp       = OIL_W'(oil);
        return t;
    endfunction

    // Pedal fraction biased toward the ends of its travel
    function automatic int pedal_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return 0;
        if (pick < 30) return 4095;
        return $urandom_range(4095);
    endfunction

    // Random tick aimed at the current stall, idle and rev thresholds
    function automatic in_item_t random_tick();
        int oil;
        int target;
        int st;
        int fly;
        int crank;
        int accel;
        int pick;
        st  = ecu_regs.stall_rpm;
        oil = int'($urandom_range(319)) - 64;
        // Noise: any legal value in every field but oil temperature
        if ($urandom_range(99) < 10) begin
            return tick_item($urandom_range(1), $urandom_range(1), $urandom_range(4095),
                             $urandom_range(4095), $urandom_range(4095),
                             $urandom_range(4095), $urandom_range(16383),
                             $urandom_range(16383), oil);
        end
        target = (oil < 90) ? int'(ecu_regs.cold_idle_rpm) : int'(ecu_regs.warm_idle_rpm);
        pick   = $urandom_range(99);
        if (pick < 40) begin
            fly = target + 5 - int'($urandom_range(ecu_regs.large_gap_rpm
                                                   + ecu_regs.small_gap_rpm + 40));
        end else if (pick < 55) begin
            fly = int'(ecu_regs.rev_limit_rpm) + int'($urandom_range(6)) - 3;
        end else if (pick < 70) begin
            case ($urandom_range(3))
                0:       fly = target - int'(ecu_regs.large_gap_rpm);
                1:       fly = target - int'(ecu_regs.large_gap_rpm) - 1;
                2:       fly = target - int'(ecu_regs.small_gap_rpm);
                default: fly = target - int'(ecu_regs.small_gap_rpm) - 1;
            endcase
        end else begin
            fly = $urandom_range(16383);
        end
        if (fly < 0) fly = 0;
        if (fly > 16383) fly = 16383;
        // Crank mostly turning so the engine reaches and stays in running
        pick = $urandom_range(99);
        if (pick < 8) begin
            crank = st;
        end else if (pick < 16) begin
            crank = (st == 0) ? 0 : st - 1;
        end else if (pick < 66) begin
            crank = st + int'($urandom_range(16383 - st));
        end else begin
            crank = (st == 0) ? 0 : int'($urandom_range(st - 1));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            accel = int'(ecu_regs.small_correction) + int'($urandom_range(2)) - 1;
        end else if (pick < 20) begin
            accel = int'(ecu_regs.large_correction) + int'($urandom_range(2)) - 1;
        end else begin
            accel = pedal_value();
        end
        if (accel < 0) accel = 0;
        if (accel > 4095) accel = 4095;
        return tick_item($urandom_range(99) < 40, $urandom_range(1), pedal_value(),
                         pedal_value(), accel, pedal_value(), crank, fly, oil);
    endfunction

    task automatic queue_random(int n);
        repeat (n) queue_tick(random_tick());
    endtask

    // Hold until every tick is accepted and every result has returned;
    // look after the driver has settled, then return on a falling edge
    task automatic wait_drained();
        do begin
            @(negedge aclk);
            #1;
        end while (pending_ticks.size() != 0 || s_tvalid || predicted_results.size() != 0);
        @(negedge aclk);
    endtask

    // Called at a falling edge; returns on a falling edge after the write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(int cold, int warm, int sgap, int lgap,
                             int scorr, int lcorr, int rev, int stall);
        write_reg(REG_COLD_IDLE,  CFG_DATA_W'(cold));
        write_reg(REG_WARM_IDLE,  CFG_DATA_W'(warm));
        write_reg(REG_SMALL_GAP,  CFG_DATA_W'(sgap));
        write_reg(REG_LARGE_GAP,  CFG_DATA_W'(lgap));
        write_reg(REG_SMALL_CORR, CFG_DATA_W'(scorr));
        write_reg(REG_LARGE_CORR, CFG_DATA_W'(lcorr));
        write_reg(REG_REV_LIMIT,  CFG_DATA_W'(rev));
        write_reg(REG_STALL,      CFG_DATA_W'(stall));
    endtask

    // Driver: present the next tick once the previous one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_ticks.size() != 0 && int'($urandom_range(99)) >= gap_pct) begin
                s_tdata  <= pending_ticks.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when kicked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_kick) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= int'($urandom_range(99)) >= stall_pct;
        end
    end

    // Monitor: mirror register writes, predict accepted ticks, check results
    always @(posedge aclk) begin : watch
        out_item_t got;
        out_item_t want;
        s_took   <= aresetn && s_tvalid && s_tready;
        cfg_took <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                predicted_results.insert(predicted_results.size(), predict_tick(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_results.size() == 0) begin
                    flag_error($sformatf("unexpected result transaction %h", m_tdata));
                end else begin
                    want = predicted_results.pop_front();
                    check_field("lights_out", want.lights_out, got.lights_out);
                    check_field("hand_brake_out", want.hand_brake_out, got.hand_brake_out);
                    check_field("clutch_out", want.clutch_out, got.clutch_out);
                    check_field("throttle_out", want.throttle_out, got.throttle_out);
                    check_field("brake_out", want.brake_out, got.brake_out);
                    check_field("starter_on", want.starter_on, got.starter_on);
                    check_field("mode_out", want.mode_out, got.mode_out);
                end
            end
        end
    end

    initial begin : stimulus
        ecu_regs = '{COLD_IDLE_RST, WARM_IDLE_RST, SMALL_GAP_RST, LARGE_GAP_RST,
                     SMALL_CORR_RST, LARGE_CORR_RST, REV_LIMIT_RST, STALL_RST};
        model_mode = MODE_OFF;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed walk through every mode and threshold at reset settings
        queue_tick(tick_item(0, 1, 0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick_item(1, 1, 4095, 0, 100, 1365, 0, 0, -64));
        queue_tick(tick_item(1, 0, 1365, 2730, 4095, 0, 549, 5500, 89));
        queue_tick(tick_item(0, 1, 2730, 1365, 0, 4095, 550, 700, 90));
        queue_tick(tick_item(0, 1, 1, 2, 0, 3, 600, 699, 90));
        queue_tick(tick_item(0, 0, 7, 8, 123, 9, 600, 790, 90));
        queue_tick(tick_item(0, 0, 7, 8, 0, 9, 600, 789, 90));
        queue_tick(tick_item(0, 1, 0, 0, 4095, 0, 600, 5499, 255));
        queue_tick(tick_item(1, 1, 4095, 4095, 4095, 4095, 16383, 16383, 255));
        queue_tick(tick_item(0, 1, 0, 0, 5, 0, 549, 0, 20));
        queue_tick(tick_item(1, 1, 0, 0, 5, 0, 550, 0, 20));
        queue_tick(tick_item(1, 1, 0, 0, 0, 0, 0, 1150, 89));
        queue_tick(tick_item(0, 1, 0, 0, 0, 0, 0, 1100, -1));
        queue_tick(tick_item(0, 0, 0, 0, 0, 0, 16383, 1099, 0));
        queue_tick(tick_item(0, 0, 0, 0, 0, 0, 0, 1099, 0));
        queue_tick(tick_item(1, 0, 0, 0, 0, 0, 549, 0, 0));
        queue_tick(tick_item(1, 0, 0, 0, 0, 0, 550, 0, 0));
        queue_random(280);
        wait_drained();

        // Mid-range settings, upper data bits set, writes to unused indexes
        write_all(16'hC5DC, 900, 16'h8028, 300, 16'hF258, 1500, 16'h4FA0, 400);
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        write_reg(REG_UNUSED_HI, 16'h0000);
        gap_pct = 60;
        queue_random(250);
        wait_drained();

        // All registers at zero
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        gap_pct   = 0;
        stall_pct = 60;
        queue_random(100);
        wait_drained();

        // All registers at their maximum
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(250);
        wait_drained();

        // Large gap set below small gap
        write_all($urandom_range(2000, 600), $urandom_range(1200, 400), 200, 50,
                  $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(8000, 2000), $urandom_range(900, 200));
        gap_pct   = 37;
        stall_pct = 37;
        queue_random(250);
        wait_drained();

        // Back to reset settings; hold the result side so the input backs up
        write_all(COLD_IDLE_RST, WARM_IDLE_RST, SMALL_GAP_RST, LARGE_GAP_RST,
                  SMALL_CORR_RST, LARGE_CORR_RST, REV_LIMIT_RST, STALL_RST);
        gap_pct   = 0;
        stall_pct = 0;
        queue_random(200);
        @(posedge aclk);
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        wait_drained();

        repeat (8) @(negedge aclk);
        if (predicted_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", predicted_results.size()));
        end
        if (errs == 0) begin
            $display("engine_power_idle_rev_controller_unit verification clean");
        end else begin
            $display("engine_power_idle_rev_controller_unit verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("engine_power_idle_rev_controller_unit verification failed");
        $finish;
    end

endmodule
